// File: src/ssrl_pkg.sv
// ----------------------------------------------------------------------------
// ssrl_pkg: shared types and constants of the sequenced slot ring log
// Holds the request and result structs, action and status codes.
// ----------------------------------------------------------------------------
package ssrl_pkg;

    localparam int SLOTS_DEF       = 512;
    localparam int MAX_PAYLOAD_DEF = 4064;

    localparam logic [2:0] ACT_PUSH   = 3'd0;
    localparam logic [2:0] ACT_POP    = 3'd1;
    localparam logic [2:0] ACT_COMMIT = 3'd2;
    localparam logic [2:0] ACT_CLEAR  = 3'd3;
    localparam logic [2:0] ACT_RESCAN = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_NO_REC  = 2'd2;
    localparam logic [1:0] ST_NO_SEQ  = 2'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] payload_length;
        logic [15:0] payload_crc;
        logic [31:0] stamp;
        logic [15:0] read_limit;
        logic [31:0] commit_seq;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rec_seq;
        logic [31:0] rec_stamp;
        logic [11:0] rec_length;
        logic [15:0] rec_crc;
        logic [8:0]  rec_slot;
        logic [9:0]  pending_count;
    } rsp_t;

    // slot record as stored in memory: seq, stamp, length, crc
    localparam int REC_W = 32 + 32 + 12 + 16;

endpackage

// File: src/ssrl_ram.sv
// ----------------------------------------------------------------------------
// ssrl_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ssrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/sequenced_slot_ring_log.sv
// ----------------------------------------------------------------------------
// sequenced_slot_ring_log: ring of record slots with sequence numbers
//
//   channel  | signals                     | handshake
//   request  | start, busy, req            | taken when start && !busy
//   result   | done, rsp                   | one-cycle strobe, not stallable
//
// A push passes through the read, check and result states (S_RD, S_CHK,
// S_DONE), a bad push length through S_RD and S_DONE, and a fast-path
// commit and an unused action go straight to S_DONE. Pop, commit search
// and rescan visit the slots one at a time, each through S_RD and S_CHK,
// since each slot read waits for the registered memory data. Clear sweeps
// the valid memory in S_CLR. done rises in the same cycle that busy falls.
// After reset a clearing pass runs with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module sequenced_slot_ring_log
    import ssrl_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_CLR   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]   state_reg, state_next;
    req_t         req_reg, req_next;
    logic [AW-1:0] wslot_reg, wslot_next;
    logic [31:0]  nseq_reg, nseq_next;
    logic [CW-1:0] pend_reg, pend_next;
    logic [AW-1:0] rcur_reg, rcur_next;
    logic [AW-1:0] lps_reg, lps_next;
    logic [31:0]  lpseq_reg, lpseq_next;
    logic [CW-1:0] k_reg, k_next;      // scan step count
    logic [AW-1:0] idx_reg, idx_next;  // address in flight
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]  best_reg, best_next;
    logic [AW-1:0] bslot_reg, bslot_next;
    logic         found_reg, found_next;
    rsp_t         rsp_reg, rsp_next;
    logic         done_reg, done_next;

    logic          v_we, v_wd, v_rd;
    logic [AW-1:0] v_wa, v_ra;
    logic          r_we;
    logic [AW-1:0] r_wa, r_ra;
    logic [REC_W-1:0] r_wd, r_rd;
    logic [31:0]  s_seq, s_stamp, d;
    logic [11:0]  s_len;
    logic [15:0]  s_crc;

    ssrl_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_valid (
        .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
    );
    ssrl_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_rec (
        .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd)
    );

    assign {s_seq, s_stamp, s_len, s_crc} = r_rd;
    assign d = s_seq - best_reg;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
        inc = (a == AW'(SLOTS - 1)) ? '0 : a + 1'b1;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        wslot_next = wslot_reg;
        nseq_next  = nseq_reg;
        pend_next  = pend_reg;
        rcur_next  = rcur_reg;
        lps_next   = lps_reg;
        lpseq_next = lpseq_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        best_next  = best_reg;
        bslot_next = bslot_reg;
        found_next = found_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        v_we = 1'b0; v_wa = idx_reg; v_wd = 1'b0; v_ra = idx_reg;
        r_we = 1'b0; r_wa = wslot_reg; r_ra = idx_reg;
        r_wd = {nseq_reg, req_reg.stamp, req_reg.payload_length[11:0], req_reg.payload_crc};
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    rsp_next = '0;
                    k_next   = '0;
                    cnt_next = '0;
                    best_next = '0;
                    bslot_next = '0;
                    found_next = 1'b0;
                    state_next = S_RD;
                    case (req.action)
                        ACT_PUSH:   idx_next = wslot_reg;
                        ACT_POP:    idx_next = rcur_reg;
                        ACT_COMMIT: idx_next = '0;
                        ACT_CLEAR:
                        begin
                            idx_next = '0;
                            state_next = S_CLR;
                        end
                        ACT_RESCAN: idx_next = '0;
                        default:    state_next = S_DONE;
                    endcase
                    v_ra = idx_next;
                    r_ra = idx_next;
                    if (req.action == ACT_COMMIT && req.commit_seq == lpseq_reg)
                    begin
                        // fast path: last popped slot
                        v_we = 1'b1; v_wa = lps_reg; v_wd = 1'b0;
                        if (pend_reg != '0) pend_next = pend_reg - 1'b1;
                        rsp_next.rec_seq  = req.commit_seq;
                        rsp_next.rec_slot = 9'(lps_reg);
                        state_next = S_DONE;
                    end
                end
            end
            S_RD:
            begin
                // read issued last cycle; data valid in S_CHK
                state_next = S_CHK;
                if (req_reg.action == ACT_PUSH)
                begin
                    if (req_reg.payload_length == '0 ||
                        32'(req_reg.payload_length) > 32'(MAX_PAYLOAD))
                    begin
                        rsp_next.status = ST_BAD_LEN;
                        state_next = S_DONE;
                    end
                end
            end
            S_CHK:
            begin
                case (req_reg.action)
                    ACT_PUSH:
                    begin
                        v_we = 1'b1; v_wa = wslot_reg; v_wd = 1'b1;
                        r_we = 1'b1;
                        rsp_next.rec_seq  = nseq_reg;
                        rsp_next.rec_slot = 9'(wslot_reg);
                        nseq_next  = nseq_reg + 1'b1;
                        wslot_next = inc(wslot_reg);
                        if (!v_rd && pend_reg < CW'(SLOTS)) pend_next = pend_reg + 1'b1;
                        state_next = S_DONE;
                    end
                    ACT_POP:
                    begin
                        state_next = S_RD;
                        if (v_rd && 16'(s_len) >= req_reg.read_limit)
                        begin
                            v_we = 1'b1; v_wd = 1'b0;
                        end
                        else if (v_rd)
                        begin
                            rcur_next  = inc(idx_reg);
                            lps_next   = idx_reg;
                            lpseq_next = s_seq;
                            rsp_next.rec_seq    = s_seq;
                            rsp_next.rec_stamp  = s_stamp;
                            rsp_next.rec_length = s_len;
                            rsp_next.rec_crc    = s_crc;
                            rsp_next.rec_slot   = 9'(idx_reg);
                            state_next = S_DONE;
                        end
                        if (state_next != S_DONE)
                        begin
                            if (k_reg == CW'(SLOTS - 1))
                            begin
                                rsp_next.status = ST_NO_REC;
                                state_next = S_DONE;
                            end
                            k_next = k_reg + 1'b1;
                            idx_next = inc(idx_reg);
                        end
                    end
                    ACT_COMMIT:
                    begin
                        state_next = S_RD;
                        if (v_rd && s_seq == req_reg.commit_seq)
                        begin
                            v_we = 1'b1; v_wd = 1'b0;
                            if (pend_reg != '0) pend_next = pend_reg - 1'b1;
                            rsp_next.rec_seq  = s_seq;
                            rsp_next.rec_slot = 9'(idx_reg);
                            state_next = S_DONE;
                        end
                        else if (k_reg == CW'(SLOTS - 1))
                        begin
                            rsp_next.status = ST_NO_SEQ;
                            state_next = S_DONE;
                        end
                        k_next = k_reg + 1'b1;
                        idx_next = inc(idx_reg);
                    end
                    default:
                    begin
                        // rescan: serial compare against best so far
                        state_next = S_RD;
                        if (v_rd)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                            if (d != '0 && !d[31])
                            begin
                                best_next  = s_seq;
                                bslot_next = idx_reg;
                                found_next = 1'b1;
                            end
                        end
                        if (k_reg == CW'(SLOTS - 1))
                        begin
                            pend_next = v_rd ? cnt_reg + 1'b1 : cnt_reg;
                            if (found_next)
                            begin
                                wslot_next = inc(bslot_next);
                                nseq_next  = best_next + 1'b1;
                            end
                            else
                            begin
                                wslot_next = '0;
                                nseq_next  = 32'd1;
                            end
                            state_next = S_DONE;
                        end
                        k_next = k_reg + 1'b1;
                        idx_next = inc(idx_reg);
                    end
                endcase
                v_ra = idx_next;
                r_ra = idx_next;
            end
            S_CLR:
            begin
                v_we = 1'b1; v_wa = idx_reg; v_wd = 1'b0;
                idx_next = inc(idx_reg);
                if (idx_reg == AW'(SLOTS - 1))
                begin
                    state_next = S_DONE;
                    wslot_next = '0;
                    nseq_next  = 32'd1;
                    pend_next  = '0;
                    rcur_next  = '0;
                end
            end
            default:
            begin
                rsp_next.pending_count = 10'(pend_reg);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
        endcase
    end

    // reset clears the valid memory through S_CLR with a reset-only request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            wslot_reg <= '0;
            nseq_reg  <= 32'd1;
            pend_reg  <= '0;
            rcur_reg  <= '0;
            lps_reg   <= '0;
            lpseq_reg <= '0;
            k_reg     <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            req_reg   <= '0;
        end
        else
        begin
            state_reg <= (state_next == S_DONE && state_reg == S_CLR &&
                          req_reg.action != ACT_CLEAR) ? S_IDLE : state_next;
            wslot_reg <= wslot_next;
            nseq_reg  <= nseq_next;
            pend_reg  <= pend_next;
            rcur_reg  <= rcur_next;
            lps_reg   <= lps_next;
            lpseq_reg <= lpseq_next;
            k_reg     <= k_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next && state_reg == S_DONE;
            found_reg <= found_next;
            req_reg   <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        best_reg  <= best_next;
        bslot_reg <= bslot_next;
        rsp_reg   <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// File: src/ssrl_checker.sv
// ----------------------------------------------------------------------------
// ssrl_checker: port-level checks of the slot ring log
// Watches the request/result handshake and result fields.
// ----------------------------------------------------------------------------
module ssrl_checker
    import ssrl_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t req,
    input logic done,
    input rsp_t rsp
);

    // accepted request makes the block busy next cycle
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("request not taken");

    // a result ends a busy period
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");

    // strobe lasts one cycle
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe too long");

    // pending never above ring size
    a_pend: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.pending_count <= 10'(SLOTS_DEF)) else $error("pending overflow");

endmodule

bind sequenced_slot_ring_log ssrl_checker u_ssrl_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .req(req), .done(done), .rsp(rsp)
);
